// File: src/lcs_pkg.sv
// Package for the linear contrast stretch block.
// Holds the configuration register map. Depends on nothing.
package lcs_pkg;

  // Width of the configuration register index.
  localparam int unsigned CFG_IDX_BITS = 2;

  // Configuration register map.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SRC_MIN = 2'd0,
    REG_SRC_MAX = 2'd1,
    REG_DST_MIN = 2'd2,
    REG_DST_MAX = 2'd3
  } lcs_reg_t;

endpackage

// File: src/linear_contrast_stretch.sv
// Top level of the linear contrast stretch: clamp, multiply, divide, offset, or pass through.
// Depends on lcs_pkg and lcs_div_step.
//
//   Channel   Direction  Handshake             Payload
//   in_       input      in_valid / in_stall   in_pixel_in   (PIXEL_BITS)
//   out_      output     out_valid / out_stall out_pixel_out (PIXEL_BITS)
//   cfg_      input      cfg_wr_en             cfg_index, cfg_data
//
// One word is accepted per clock while in_stall is low. A word passes
// PIXEL_BITS + 3 register stages: front, multiply, one divider stage per
// quotient bit, and the output stage, which holds the result.
// Reset (rst_n low, synchronous) empties the pipeline and loads the default
// mapping, source range 0..255 onto destination range 0..255, cut to PIXEL_BITS.
// A stall on the output only holds the stages that are full; bubbles further
// up close, so the input keeps taking words until the whole pipeline is full.
module linear_contrast_stretch #(
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input pixel channel.
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [PIXEL_BITS-1:0]            in_pixel_in,
  // Result pixel channel.
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [PIXEL_BITS-1:0]            out_pixel_out,
  // Configuration write port.
  input  logic                             cfg_wr_en,
  input  logic [lcs_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [PIXEL_BITS-1:0]            cfg_data
);

  localparam int unsigned N = PIXEL_BITS;
  // Front stage, multiply stage, N divider stages and the output stage.
  localparam int unsigned NS = N + 3;
  localparam int unsigned DIV0 = 2;
  // Reset value of both range maxima.
  localparam logic [N-1:0] RESET_MAX = N'(255);

  // Configuration registers.
  logic [N-1:0] src_min_r, src_max_r, dst_min_r, dst_max_r;

  // Valid bit of every stage and the per-stage load enables.
  logic [NS-1:0] v_r;
  logic [NS:0]   ld;

  // The chain of load enables lets a stage take a new word when it is empty
  // or when the stage after it moves on in the same cycle.
  always_comb begin
    ld[NS] = !out_stall;
    for (int k = NS - 1; k >= 0; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
  end

  assign in_stall = !ld[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (ld[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Configuration writes. The map covers every index, so none is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_min_r <= '0;
      src_max_r <= RESET_MAX;
      dst_min_r <= '0;
      dst_max_r <= RESET_MAX;
    end else if (cfg_wr_en) begin
      case (lcs_pkg::lcs_reg_t'(cfg_index))
        lcs_pkg::REG_SRC_MIN: src_min_r <= cfg_data;
        lcs_pkg::REG_SRC_MAX: src_max_r <= cfg_data;
        lcs_pkg::REG_DST_MIN: dst_min_r <= cfg_data;
        lcs_pkg::REG_DST_MAX: dst_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Stage 0: clamp the pixel to the source range and take it relative to
  // src_min. The destination span is split into a magnitude and a sign so
  // the divider works on unsigned values; truncation toward zero then falls
  // out of dividing the magnitude and applying the sign afterwards.
  // ---------------------------------------------------------------------
  logic [N-1:0] clamp_pix;
  logic [N-1:0] d_nxt, span_nxt, mag_nxt;
  logic         neg_nxt, byp_nxt;

  always_comb begin
    if (in_pixel_in < src_min_r) begin
      clamp_pix = src_min_r;
    end else if (in_pixel_in > src_max_r) begin
      clamp_pix = src_max_r;
    end else begin
      clamp_pix = in_pixel_in;
    end
    d_nxt    = clamp_pix - src_min_r;
    span_nxt = src_max_r - src_min_r;
    neg_nxt  = (dst_max_r < dst_min_r);
    mag_nxt  = neg_nxt ? (dst_min_r - dst_max_r) : (dst_max_r - dst_min_r);
    // An empty or reversed source range passes the pixel through.
    byp_nxt  = (src_min_r >= src_max_r);
  end

  logic [N-1:0] d0_r, span0_r, mag0_r, pix0_r, dmin0_r;
  logic         neg0_r, byp0_r;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      d0_r    <= d_nxt;
      span0_r <= span_nxt;
      mag0_r  <= mag_nxt;
      pix0_r  <= in_pixel_in;
      dmin0_r <= dst_min_r;
      neg0_r  <= neg_nxt;
      byp0_r  <= byp_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: product of the offset pixel and the destination magnitude.
  // ---------------------------------------------------------------------
  logic [2*N-1:0] prod1_r;
  logic [N-1:0]   span1_r, pix1_r, dmin1_r;
  logic           neg1_r, byp1_r;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      prod1_r <= d0_r * mag0_r;
      span1_r <= span0_r;
      pix1_r  <= pix0_r;
      dmin1_r <= dmin0_r;
      neg1_r  <= neg0_r;
      byp1_r  <= byp0_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stages 2 .. N+1: restoring division, one quotient bit per stage. The
  // product never exceeds span * (2^N - 1), so its upper half starts below
  // the divisor and N quotient bits hold the whole result.
  // ---------------------------------------------------------------------
  logic [N-1:0] span_s [N+1];
  logic [N-1:0] rem_s  [N+1];
  logic [N-1:0] low_s  [N+1];
  logic [N-1:0] quo_s  [N+1];

  // Side data that rides along with each divider stage.
  logic [N-1:0] pix_d_r  [N];
  logic [N-1:0] dmin_d_r [N];
  logic         neg_d_r  [N];
  logic         byp_d_r  [N];

  assign span_s[0] = span1_r;
  assign rem_s[0]  = prod1_r[2*N-1:N];
  assign low_s[0]  = prod1_r[N-1:0];
  assign quo_s[0]  = '0;

  for (genvar k = 0; k < N; k++) begin : g_div
    lcs_div_step #(
      .W (N)
    ) u_step (
      .clk    (clk),
      .load   (ld[DIV0+k]),
      .span_i (span_s[k]),
      .rem_i  (rem_s[k]),
      .low_i  (low_s[k]),
      .quo_i  (quo_s[k]),
      .span_o (span_s[k+1]),
      .rem_o  (rem_s[k+1]),
      .low_o  (low_s[k+1]),
      .quo_o  (quo_s[k+1])
    );

    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (ld[DIV0]) begin
          pix_d_r[0]  <= pix1_r;
          dmin_d_r[0] <= dmin1_r;
          neg_d_r[0]  <= neg1_r;
          byp_d_r[0]  <= byp1_r;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (ld[DIV0+k]) begin
          pix_d_r[k]  <= pix_d_r[k-1];
          dmin_d_r[k] <= dmin_d_r[k-1];
          neg_d_r[k]  <= neg_d_r[k-1];
          byp_d_r[k]  <= byp_d_r[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output stage: apply the sign, add dst_min, or pass the pixel through.
  // With a proper source range the sum always lies within the destination
  // range, so wrapping to N bits changes nothing.
  // ---------------------------------------------------------------------
  logic [N-1:0] quo_fin, res_nxt, out_r;

  always_comb begin
    quo_fin = quo_s[N];
    if (byp_d_r[N-1]) begin
      res_nxt = pix_d_r[N-1];
    end else if (neg_d_r[N-1]) begin
      res_nxt = dmin_d_r[N-1] - quo_fin;
    end else begin
      res_nxt = dmin_d_r[N-1] + quo_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[NS-1]) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid     = v_r[NS-1];
  assign out_pixel_out = out_r;

  // The remainder, low bits and divisor leaving the last divider stage are
  // not needed past that point.
  logic unused_tail;
  assign unused_tail = ^{span_s[N], rem_s[N], low_s[N]};

endmodule

// File: src/lcs_div_step.sv
// One registered step of the restoring divider used by the contrast stretch.
// Produces one quotient bit per stage. Depends on nothing.
module lcs_div_step #(
  parameter int unsigned W = 8
) (
  input  logic         clk,
  input  logic         load,
  input  logic [W-1:0] span_i,
  input  logic [W-1:0] rem_i,
  input  logic [W-1:0] low_i,
  input  logic [W-1:0] quo_i,
  output logic [W-1:0] span_o,
  output logic [W-1:0] rem_o,
  output logic [W-1:0] low_o,
  output logic [W-1:0] quo_o
);

  logic [W:0]   trial;
  logic         fits;
  logic [W:0]   diff;
  logic [W-1:0] span_r, rem_r, low_r, quo_r;
  logic [W-1:0] rem_nxt, low_nxt, quo_nxt;

  // The partial remainder is always below the divisor, so after the
  // conditional subtract it fits back into W bits.
  always_comb begin
    trial   = {rem_i, low_i[W-1]};
    fits    = (trial >= {1'b0, span_i});
    diff    = trial - {1'b0, span_i};
    rem_nxt = fits ? diff[W-1:0] : trial[W-1:0];
    low_nxt = {low_i[W-2:0], 1'b0};
    quo_nxt = {quo_i[W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      span_r <= span_i;
      rem_r  <= rem_nxt;
      low_r  <= low_nxt;
      quo_r  <= quo_nxt;
    end
  end

  assign span_o = span_r;
  assign rem_o  = rem_r;
  assign low_o  = low_r;
  assign quo_o  = quo_r;

endmodule

// File: test/lcs_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the linear contrast stretch block: predicts and checks every output word.
// Depends on lcs_pkg for the register map.
module lcs_checker #(
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [PIXEL_BITS-1:0]            in_pixel_in,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [PIXEL_BITS-1:0]            out_pixel_out,
  input  logic                             cfg_wr_en,
  input  logic [lcs_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [PIXEL_BITS-1:0]            cfg_data,
  output int                               words_in_flight,
  output int                               mismatch_count
);

  typedef logic [PIXEL_BITS-1:0] pixel_t;

  // Reset value of both range maxima.
  localparam pixel_t RESET_MAX = pixel_t'(255);

  pixel_t src_lo = '0;
  pixel_t src_hi = RESET_MAX;
  pixel_t dst_lo = '0;
  pixel_t dst_hi = RESET_MAX;
  pixel_t expected_pixels[$];

  // Clamp to the source range, then scale onto the destination range.
  // Integer division truncates toward zero, which handles a falling destination range.
  function automatic pixel_t stretch_pixel(pixel_t p);
    longint clamped;
    longint num;
    longint span;
    if (src_lo >= src_hi) return p;
    clamped = longint'(p);
    if (clamped < longint'(src_lo)) clamped = longint'(src_lo);
    if (clamped > longint'(src_hi)) clamped = longint'(src_hi);
    num  = (clamped - longint'(src_lo)) * (longint'(dst_hi) - longint'(dst_lo));
    span = longint'(src_hi) - longint'(src_lo);
    return pixel_t'(num / span + longint'(dst_lo));
  endfunction

  always @(posedge clk) begin
    pixel_t expected;
    if (!rst_n) begin
      src_lo = '0;
      src_hi = RESET_MAX;
      dst_lo = '0;
      dst_hi = RESET_MAX;
      expected_pixels.delete();
    end else begin
      if (cfg_wr_en) begin
        case (lcs_pkg::lcs_reg_t'(cfg_index))
          lcs_pkg::REG_SRC_MIN: src_lo = cfg_data;
          lcs_pkg::REG_SRC_MAX: src_hi = cfg_data;
          lcs_pkg::REG_DST_MIN: dst_lo = cfg_data;
          lcs_pkg::REG_DST_MAX: dst_hi = cfg_data;
          default: ;
        endcase
      end
      // Check the output before queuing a new input, so a word that shows up
      // with nothing pending is never matched against one issued this cycle.
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected output word, expected none, got pixel_out %0d",
                   $time, out_pixel_out);
          mismatch_count++;
        end else begin
          expected = expected_pixels.pop_front();
          if (out_pixel_out !== expected) begin
            $display("%0t: pixel_out mismatch, expected %0d, got %0d",
                     $time, expected, out_pixel_out);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) expected_pixels.push_back(stretch_pixel(in_pixel_in));
    end
    words_in_flight = expected_pixels.size();
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// Testbench top for the linear contrast stretch block: stimulus, stalls and the verdict.
// Depends on lcs_pkg, linear_contrast_stretch and lcs_checker.
module tb;

  localparam int unsigned PIXEL_BITS = 8;
  // Pipeline depth from acceptance to the output register.
  localparam int unsigned LATENCY = PIXEL_BITS + 3;
  // Cycles without any accepted word or register write before the run is declared hung.
  localparam int unsigned HANG_LIMIT = 5000;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned WORDS_PER_PHASE = 125;

  typedef logic [PIXEL_BITS-1:0] pixel_t;
  localparam pixel_t PIX_TOP = '1;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  pixel_t                           in_pixel_in = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  pixel_t                           out_pixel_out;
  logic                             cfg_wr_en = 1'b0;
  logic [lcs_pkg::CFG_IDX_BITS-1:0] cfg_index = lcs_pkg::REG_SRC_MIN;
  pixel_t                           cfg_data = '0;

  int words_in_flight;
  int mismatch_count;

  // Idle and stall probabilities in percent, changed per phase. When quiet is
  // set neither side inserts bubbles, so the end of the run streams at full rate.
  int idle_pct = 0;
  int stall_pct = 0;
  bit quiet = 1'b0;
  int stall_burst = 0;
  int hang_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  linear_contrast_stretch #(.PIXEL_BITS(PIXEL_BITS)) uut (.*);

  lcs_checker #(.PIXEL_BITS(PIXEL_BITS)) scoreboard (.*);

  // Output back-pressure: stall bursts of random length, started at random.
  // Driven on the falling edge so the block samples a settled value.
  always @(negedge clk) begin
    if (!rst_n || quiet) begin
      stall_burst = 0;
      out_stall <= 1'b0;
    end else if (stall_burst > 0) begin
      stall_burst--;
      out_stall <= 1'b1;
    end else if ($urandom_range(99) < stall_pct) begin
      stall_burst = $urandom_range(3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: any accepted word or register write restarts the count. A lost
  // result leaves the drain loop waiting forever, and this is what ends it.
  always @(posedge clk) begin
    if (!rst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      hang_cycles <= 0;
    end else if (hang_cycles >= HANG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      hang_cycles <= hang_cycles + 1;
    end
  end

  // Drops valid and waits until every predicted word has come out. Each input
  // word yields exactly one output, so an empty queue means an empty pipeline.
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (words_in_flight != 0) @(negedge clk);
  endtask

  // Writes all four registers, one per cycle, once the block has gone idle.
  task automatic load_mapping(pixel_t smin, pixel_t smax, pixel_t dmin, pixel_t dmax);
    pixel_t            vals[4];
    lcs_pkg::lcs_reg_t regs[4];
    vals = '{smin, smax, dmin, dmax};
    regs = '{lcs_pkg::REG_SRC_MIN, lcs_pkg::REG_SRC_MAX,
             lcs_pkg::REG_DST_MIN, lcs_pkg::REG_DST_MAX};
    wait_for_drain();
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
    end
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Presents one word, optionally after a short bubble, and holds it until
  // the block takes it. Valid stays high between back-to-back words.
  task automatic send_pixel(pixel_t p);
    int gap;
    if (!quiet && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 4);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_pixel_in <= p;
    do @(posedge clk); while (in_stall);
  endtask

  // One random phase: pick a mapping of a random kind, pick the bubble rates,
  // then stream words. Four words in ten land at or near the clamp
  // bounds, where off-by-one errors in the clamp and the scale show up.
  task automatic run_random_phase(int count);
    pixel_t smin;
    pixel_t smax;
    pixel_t dmin;
    pixel_t dmax;
    int     pick;
    int     bound;
    dmin = pixel_t'($urandom);
    dmax = pixel_t'($urandom);
    case ($urandom_range(5))
      0: begin
        // Anything at all, including empty and reversed source ranges.
        smin = pixel_t'($urandom);
        smax = pixel_t'($urandom);
      end
      1: begin
        // Empty source range: the block must pass pixels through.
        smin = pixel_t'($urandom);
        smax = smin;
      end
      2: begin
        // Reversed source range: also a pass-through.
        smax = pixel_t'($urandom_range(0, PIX_TOP - 1));
        smin = pixel_t'($urandom_range(smax + 1, PIX_TOP));
      end
      3: begin
        smin = pixel_t'($urandom_range(0, PIX_TOP - 1));
        smax = pixel_t'($urandom_range(smin + 1, PIX_TOP));
      end
      4: begin
        // Full source range onto a destination made of extreme values.
        smin = '0;
        smax = PIX_TOP;
        dmin = $urandom_range(1) ? PIX_TOP : pixel_t'(0);
        dmax = $urandom_range(1) ? PIX_TOP : pixel_t'(0);
      end
      default: begin
        // A source range only a few levels wide gives the largest gain.
        smin = pixel_t'($urandom_range(0, PIX_TOP - 3));
        smax = smin + pixel_t'($urandom_range(1, 3));
      end
    endcase
    load_mapping(smin, smax, dmin, dmax);
    idle_pct  = 15 * $urandom_range(2);
    stall_pct = 15 * $urandom_range(2);
    repeat (count) begin
      pick = $urandom_range(9);
      if (pick < 6) begin
        send_pixel(pixel_t'($urandom));
      end else begin
        bound = (pick < 8) ? int'(smin) : int'(smax);
        bound = bound + int'($urandom_range(4)) - 2;
        if (bound < 0) bound = 0;
        if (bound > int'(PIX_TOP)) bound = int'(PIX_TOP);
        send_pixel(pixel_t'(bound));
      end
    end
  endtask

  initial begin
    pixel_t probe[$];

    // Reset is held from time zero and released on a falling edge.
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    idle_pct  = 20;
    stall_pct = 20;

    // Reset mapping is the identity: extremes and alternating bit patterns.
    probe = '{'0, PIX_TOP, 1, pixel_t'(PIX_TOP - 1), 8'h55, 8'hAA};
    foreach (probe[i]) send_pixel(probe[i]);

    // Ordinary stretch, with words below, on and above both clamp bounds.
    load_mapping(50, 200, 10, 240);
    probe = '{'0, 49, 50, 125, 200, 201, PIX_TOP};
    foreach (probe[i]) send_pixel(probe[i]);

    // Empty source range passes the pixel unchanged.
    load_mapping(90, 90, 0, PIX_TOP);
    probe = '{89, 90, 91};
    foreach (probe[i]) send_pixel(probe[i]);

    // Reversed source range is also a pass-through.
    load_mapping(200, 100, 0, PIX_TOP);
    probe = '{'0, 150, PIX_TOP};
    foreach (probe[i]) send_pixel(probe[i]);

    // Reversed destination range inverts the image.
    load_mapping(0, PIX_TOP, PIX_TOP, 0);
    probe = '{'0, 128, PIX_TOP};
    foreach (probe[i]) send_pixel(probe[i]);

    // Single-step source range onto a flat destination.
    load_mapping(pixel_t'(PIX_TOP - 1), PIX_TOP, 7, 7);
    probe = '{'0, PIX_TOP};
    foreach (probe[i]) send_pixel(probe[i]);

    // Random phases; the last one runs without bubbles on either side.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == RANDOM_PHASES - 1) quiet = 1'b1;
      run_random_phase(WORDS_PER_PHASE);
    end

    wait_for_drain();
    repeat (LATENCY + 4) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
